// File: rtl/fa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fa_pkg
// Shared types and constants of the fit allocator: stream field layout,
// register indexes, placement policy codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fa_pkg;

    // Stream field widths and positions
    localparam int unsigned IDX_FIELD_W  = 4;
    localparam int unsigned SIZE_FIELD_W = 16;
    localparam int unsigned TDATA_W      = 24;
    localparam int unsigned IDX_LSB      = 0;
    localparam int unsigned SIZE_LSB     = 4;

    // Opcode carried in s_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Placement policy codes; the unused code acts as first fit
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_item;  // latch the accepted item, reset the scan
        logic scan_en;    // step the table scan
        logic finish;     // write back and load the result register
    } fa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // no more entries to read
        logic out_free;   // result register can take a new result
    } fa_sts_t;

endpackage : fa_pkg
`default_nettype wire

// File: rtl/fa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fa_ctrl
// Controller: accepts one item at a time, runs the scan for requests and
// hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module fa_ctrl
    import fa_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_opcode,
    output logic         s_tready,
    input  wire fa_sts_t sts,
    output fa_cmd_t      cmd
);

    fa_state_t state_reg;
    fa_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_opcode == OP_REQUEST) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.scan_en   = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_item = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule : fa_ctrl
`default_nettype wire

// File: rtl/fa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fa_datapath
// Free-size table, configuration registers, one-entry-per-cycle scan with
// pick tracking, write-back and the result register.
// ----------------------------------------------------------------------------
module fa_datapath
    import fa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [TDATA_W-1:0]    s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [TDATA_W-1:0]         m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast,
    input  wire fa_cmd_t               cmd,
    output fa_sts_t                    sts
);

    localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

    // Configuration
    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] count_reg;

    // Latched item
    logic                   op_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0]   sz_reg;
    logic                   end_reg;

    // Scan state
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     addr_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_tag_reg;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] pick_val_reg;

    // Table
    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;

    // Result register
    logic                    out_vld_reg;
    logic                    out_grant_reg;
    logic [IDX_FIELD_W-1:0]  out_idx_reg;
    logic [SIZE_FIELD_W-1:0] out_space_reg;
    logic                    out_last_reg;

    logic [CNT_W-1:0]     n_clamp;
    logic                 issue;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] entry_val;
    logic                 fits;
    logic                 take_pick;
    logic [SIZE_BITS-1:0] remain;
    logic                 load_ok;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_FIRST;
            count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIT_MODE:    mode_reg  <= cfg_data[1:0];
                CFG_BLOCK_COUNT: count_reg <= cfg_data;
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    // Active block count, limited to the table depth
    assign n_clamp = (32'(count_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                   : CNT_W'(count_reg);

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg  <= s_tuser;
            idx_reg <= s_tdata[IDX_LSB +: IDX_FIELD_W];
            sz_reg  <= SIZE_BITS'(s_tdata[SIZE_LSB +: SIZE_FIELD_W]);
            end_reg <= s_tlast;
            n_reg   <= n_clamp;
        end
    end

    // Scan address and read pipeline
    assign issue   = cmd.scan_en && (addr_reg != n_reg);
    assign rd_addr = addr_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            addr_reg   <= '0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.take_item) begin
                addr_reg <= '0;
            end else if (issue) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
            rd_tag_reg  <= rd_addr;
        end
    end

    // Compare stage: never-written entries read as zero
    assign entry_val = valid_reg[rd_tag_reg] ? rd_data_reg : '0;
    assign fits      = (entry_val >= sz_reg);
    assign take_pick = rd_vld_reg && fits &&
                       (!found_reg ||
                        ((mode_reg == MODE_BEST)  && (entry_val < pick_val_reg)) ||
                        ((mode_reg == MODE_WORST) && (entry_val > pick_val_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.take_item) begin
            found_reg <= 1'b0;
        end else if (take_pick) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_pick) begin
            pick_reg     <= rd_tag_reg;
            pick_val_reg <= entry_val;
        end
    end

    // Write-back
    assign remain  = pick_val_reg - sz_reg;
    assign load_ok = ({{(32-IDX_FIELD_W){1'b0}}, idx_reg} < 32'(NUM_BLOCKS));

    always_comb begin
        if (op_reg == OP_REQUEST) begin
            mem_we  = cmd.finish && found_reg;
            wr_addr = pick_reg;
            wr_data = remain;
        end else begin
            mem_we  = cmd.finish && load_ok;
            wr_addr = IDX_W'(idx_reg);
            wr_data = sz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (op_reg == OP_REQUEST) begin
                out_grant_reg <= found_reg;
                out_idx_reg   <= found_reg ? IDX_FIELD_W'(pick_reg) : '0;
                out_space_reg <= found_reg ? SIZE_FIELD_W'(remain) : '0;
                out_last_reg  <= end_reg;
            end else begin
                out_grant_reg <= 1'b0;
                out_idx_reg   <= '0;
                out_space_reg <= load_ok ? SIZE_FIELD_W'(sz_reg) : '0;
                out_last_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_grant_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_W-SIZE_FIELD_W-IDX_FIELD_W){1'b0}},
                       out_space_reg, out_idx_reg};

    // Status
    assign sts.scan_done = (addr_reg == n_reg);
    assign sts.out_free  = !out_vld_reg || m_tready;

endmodule : fa_datapath
`default_nettype wire

// File: rtl/fit_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fit_allocator_unit
// Memory block placement by first, best or worst fit over a table of free
// sizes, with a load operation to set a block's size.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Content
//  s_       in         s_tvalid/s_tready    load or request item
//  m_       out        m_tvalid/m_tready    one result per item
//  cfg_     in         cfg_valid/cfg_ready  fit_mode (0), block_count (1)
//
//  A request scans n table entries after acceptance, n the active
//  block count limited to NUM_BLOCKS: the scan reads one table entry per
//  cycle through the registered memory read port. A load skips the scan.
//  One item is in work at a time; the next is taken while a result waits.
//  Reset clears state, configuration and the per-entry valid bits at once.
//  A stalled m_ side holds the item in its last cycle until the result
//  register frees.
//
module fit_allocator_unit
    import fa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,   // [3:0] load_index, [19:4] size_value
    input  wire logic                  s_tuser,   // [0] opcode
    input  wire logic                  s_tlast,   // last_request
    // Results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // [3:0] block_index, [19:4] space_left
    output logic                       m_tuser,   // [0] granted
    output logic                       m_tlast    // batch_end
);

    fa_cmd_t cmd;
    fa_sts_t sts;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    fa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule : fit_allocator_unit
`default_nettype wire

// File: rtl/fa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fa_checker
// Port-level checks of the fit allocator: result hold under stall, reset
// behavior, one item at a time and the miss/load index encoding.
// ----------------------------------------------------------------------------
module fa_checker
    import fa_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser,
    input wire logic               m_tlast
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
    else $error("result valid after reset");

    // Only one item in work: input closes after a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

    // Misses and loads carry block index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[IDX_FIELD_W-1:0] == '0))
    else $error("nonzero block index without a grant");

endmodule : fa_checker

bind fit_allocator_unit fa_checker u_fa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
